// ===== design/tfsk_pkg.sv =====
// ----------------------------------------------------------------------------
// tfsk_pkg
// Shared types and constants of the four-tone FSK phasor generator.
// ----------------------------------------------------------------------------
package tfsk_pkg;

    // Signed Q2.14 value, 16384 is 1.0.
    typedef logic signed [15:0] t_q14;

    // Output sample, half of the phasor sine.
    typedef logic signed [14:0] t_sample;

    // Tone symbol.
    typedef logic [1:0] t_symbol;

    // Byte address on the configuration port.
    typedef logic [4:0] t_paddr;

    // One rotation step: cosine and sine of the per-sample phase increment.
    typedef struct packed {
        t_q14 cos;
        t_q14 sin;
    } t_step_pair;

    // Step registers, one pair per symbol.
    typedef struct packed {
        t_step_pair step3;
        t_step_pair step2;
        t_step_pair step1;
        t_step_pair step0;
    } t_step_bank;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STEP_COS_SYM0 = 3'd0,
        REG_STEP_SIN_SYM0 = 3'd1,
        REG_STEP_COS_SYM1 = 3'd2,
        REG_STEP_SIN_SYM1 = 3'd3,
        REG_STEP_COS_SYM2 = 3'd4,
        REG_STEP_SIN_SYM2 = 3'd5,
        REG_STEP_COS_SYM3 = 3'd6,
        REG_STEP_SIN_SYM3 = 3'd7
    } t_reg_idx;

    // Fixed-point constants.
    localparam t_q14 C_ONE_Q14  = 16'sd16384;
    localparam t_q14 C_ZERO_Q14 = 16'sd0;

    // Reset value of every step pair: a rotation by zero.
    localparam t_step_pair C_STEP_RESET = '{cos: C_ONE_Q14, sin: C_ZERO_Q14};

    localparam t_step_bank C_BANK_RESET = '{
        step3: C_STEP_RESET,
        step2: C_STEP_RESET,
        step1: C_STEP_RESET,
        step0: C_STEP_RESET
    };

endpackage

// ===== design/tfsk_regs.sv =====
// ----------------------------------------------------------------------------
// tfsk_regs
// Step register bank with its APB-style port, and the step pair lookup
// for the symbol under processing.
// ----------------------------------------------------------------------------
module tfsk_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  tfsk_pkg::t_paddr       paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  tfsk_pkg::t_symbol      i_symbol,
    output tfsk_pkg::t_step_pair   o_step
);
    import tfsk_pkg::*;

    t_step_bank r_bank;
    t_step_bank n_bank;
    t_reg_idx   reg_idx;
    logic       wr_en;
    t_q14       rd_value;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    // Next value of the bank on a write.
    always_comb begin
        n_bank = r_bank;
        if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_COS_SYM0: n_bank.step0.cos = pwdata[15:0];
                REG_STEP_SIN_SYM0: n_bank.step0.sin = pwdata[15:0];
                REG_STEP_COS_SYM1: n_bank.step1.cos = pwdata[15:0];
                REG_STEP_SIN_SYM1: n_bank.step1.sin = pwdata[15:0];
                REG_STEP_COS_SYM2: n_bank.step2.cos = pwdata[15:0];
                REG_STEP_SIN_SYM2: n_bank.step2.sin = pwdata[15:0];
                REG_STEP_COS_SYM3: n_bank.step3.cos = pwdata[15:0];
                REG_STEP_SIN_SYM3: n_bank.step3.sin = pwdata[15:0];
            endcase
        end
    end

    // Register bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= C_BANK_RESET;
        end else begin
            r_bank <= n_bank;
        end
    end

    // Read data, sign extended to the bus width.
    always_comb begin
        unique case (reg_idx)
            REG_STEP_COS_SYM0: rd_value = r_bank.step0.cos;
            REG_STEP_SIN_SYM0: rd_value = r_bank.step0.sin;
            REG_STEP_COS_SYM1: rd_value = r_bank.step1.cos;
            REG_STEP_SIN_SYM1: rd_value = r_bank.step1.sin;
            REG_STEP_COS_SYM2: rd_value = r_bank.step2.cos;
            REG_STEP_SIN_SYM2: rd_value = r_bank.step2.sin;
            REG_STEP_COS_SYM3: rd_value = r_bank.step3.cos;
            REG_STEP_SIN_SYM3: rd_value = r_bank.step3.sin;
        endcase
    end

    assign prdata = {{16{rd_value[15]}}, rd_value};

    // Step pair selected by the symbol.
    always_comb begin
        unique case (i_symbol)
            2'd0: o_step = r_bank.step0;
            2'd1: o_step = r_bank.step1;
            2'd2: o_step = r_bank.step2;
            2'd3: o_step = r_bank.step3;
        endcase
    end

endmodule

// ===== design/tfsk_rotator.sv =====
// ----------------------------------------------------------------------------
// tfsk_rotator
// One complex rotation of the phasor in Q2.14 with rounding and saturation,
// plus the halved sine that forms the output sample.
// ----------------------------------------------------------------------------
module tfsk_rotator (
    input  tfsk_pkg::t_q14         i_cos,
    input  tfsk_pkg::t_q14         i_sin,
    input  logic                   i_restart,
    input  tfsk_pkg::t_step_pair   i_step,
    output tfsk_pkg::t_q14         o_cos,
    output tfsk_pkg::t_q14         o_sin,
    output tfsk_pkg::t_sample      o_sample
);
    import tfsk_pkg::*;

    localparam logic signed [32:0] C_ROUND = 33'sd8192;

    t_q14                c_in;
    t_q14                s_in;
    logic signed [31:0]  p_cc;
    logic signed [31:0]  p_ss;
    logic signed [31:0]  p_sc;
    logic signed [31:0]  p_cs;
    logic signed [32:0]  acc_cos;
    logic signed [32:0]  acc_sin;
    logic signed [18:0]  q_cos;
    logic signed [18:0]  q_sin;

    // Clamp a rescaled sum to the 16-bit range.
    function automatic t_q14 sat16(input logic signed [18:0] v);
        t_q14 r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // A restart rotates from the unit phasor.
    assign c_in = i_restart ? C_ONE_Q14  : i_cos;
    assign s_in = i_restart ? C_ZERO_Q14 : i_sin;

    // Four parallel products.
    assign p_cc = c_in * i_step.cos;
    assign p_ss = s_in * i_step.sin;
    assign p_sc = s_in * i_step.cos;
    assign p_cs = c_in * i_step.sin;

    // Sums with the rounding offset; the top bits are the floor shift by 14.
    assign acc_cos = 33'(p_cc) - 33'(p_ss) + C_ROUND;
    assign acc_sin = 33'(p_sc) + 33'(p_cs) + C_ROUND;
    assign q_cos   = acc_cos[32:14];
    assign q_sin   = acc_sin[32:14];

    assign o_cos    = sat16(q_cos);
    assign o_sin    = sat16(q_sin);
    // Floor halving of the new sine.
    assign o_sample = o_sin[15:1];

endmodule

// ===== design/four_tone_fsk_phasor_generator_core.sv =====
// ----------------------------------------------------------------------------
// four_tone_fsk_phasor_generator_core
// Continuous-phase 4-FSK tone generator built on a recursive phasor.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item carries a two-bit symbol and a restart flag. The symbol
//   picks one of four rotation steps (cos, sin in Q2.14) held in the step
//   registers; the phasor is rotated by that step, after being set to (1, 0)
//   when restart is high, and one output item carries half of the new sine.
//   Step registers are written over the APB-style port at byte address 4*i,
//   and the user must change them only while no item is in flight (unchecked).
// Timing:
//   An accepted item is held in the input register, where the four
//   multipliers and the round/saturate logic update the phasor, and its
//   sample is then registered in the output register. One item per cycle is
//   sustained while the receiver does not stall; the rate is set by the
//   phasor feedback loop through the multipliers.
// Reset and stalls:
//   Reset restores the unit phasor and zero-angle steps and empties both
//   registers. When the receiver stalls, the held sample stays put, one more
//   item is taken into the input register, and then o_ready drops.
// ----------------------------------------------------------------------------
module four_tone_fsk_phasor_generator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfsk_pkg::t_symbol   i_symbol,
    input  logic                i_restart,
    output logic                o_valid,
    input  logic                i_ready,
    output tfsk_pkg::t_sample   o_sample,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  tfsk_pkg::t_paddr    paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tfsk_pkg::*;

    logic       r_s1_valid;
    t_symbol    r_symbol;
    logic       r_restart;
    logic       r_out_valid;
    t_sample    r_sample;
    t_q14       r_cos;
    t_q14       r_sin;

    logic       in_acc;
    logic       s1_adv;
    logic       out_acc;
    t_step_pair step;
    t_q14       rot_cos;
    t_q14       rot_sin;
    t_sample    rot_sample;

    // Handshake: the input register moves on when the output is free or taken.
    assign out_acc = r_out_valid & i_ready;
    assign s1_adv  = r_s1_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_s1_valid | s1_adv;
    assign in_acc  = i_valid & o_ready;
    assign o_valid = r_out_valid;
    assign o_sample = r_sample;

    // Step registers and lookup.
    tfsk_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_symbol (r_symbol),
        .o_step   (step)
    );

    // Rotation datapath.
    tfsk_rotator u_rotator (
        .i_cos     (r_cos),
        .i_sin     (r_sin),
        .i_restart (r_restart),
        .i_step    (step),
        .o_cos     (rot_cos),
        .o_sin     (rot_sin),
        .o_sample  (rot_sample)
    );

    // Valid flags and phasor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cos       <= C_ONE_Q14;
            r_sin       <= C_ZERO_Q14;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_cos       <= rot_cos;
                r_sin       <= rot_sin;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_symbol  <= i_symbol;
            r_restart <= i_restart;
        end
        if (s1_adv) begin
            r_sample <= rot_sample;
        end
    end

    // The phasor changes only when an item moves to the output register.
    a_phasor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> ($stable(r_cos) && $stable(r_sin)))
        else $error("phasor changed without an item advancing");

    // The held sample always matches the current phasor sine.
    a_sample_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_sample == r_sin[15:1]))
        else $error("output sample does not match phasor sine");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("input stalled while output register is empty");

    // A pending item reaches an empty output register in the next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("pending item did not reach the output register");

endmodule
